// File: rtl/core/bbss_pkg.sv
// ----------------------------------------------------------------------------
// Broadcast block scheduler package
// Shared types, codes and constants for the scheduler and segmenter.
// ----------------------------------------------------------------------------
package bbss_pkg;

	localparam int SCHED_ENTRIES_DEF   = 8;
	localparam int MAX_BLOCK_BYTES_DEF = 4095;
	localparam int UNKNOWN_LEN         = 10000;
	localparam int QUEUE_DEPTH         = 2;

	// Input kinds.
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_SCHED  = 2'd1;
	localparam logic [1:0] KIND_LENGTH = 2'd2;

	// Segment kinds.
	localparam logic [2:0] SEG_NONE  = 3'd0;
	localparam logic [2:0] SEG_COMPL = 3'd1;
	localparam logic [2:0] SEG_FIRST = 3'd2;
	localparam logic [2:0] SEG_SUBS  = 3'd3;
	localparam logic [2:0] SEG_LAST  = 3'd4;

	// Block kinds with a special meaning.
	localparam logic [2:0] BLK_NONE    = 3'd0;
	localparam logic [2:0] BLK_MASTER  = 3'd1;
	localparam logic [2:0] BLK_SIB1    = 3'd2;
	localparam logic [2:0] BLK_UNKNOWN = 3'd7;

	// Configuration register indexes.
	localparam logic [2:0] REG_MASTER_REP = 3'd0;
	localparam logic [2:0] REG_MASTER_POS = 3'd1;
	localparam logic [2:0] REG_SIB1_POS   = 3'd2;
	localparam logic [2:0] REG_COMPL_LIM  = 3'd3;
	localparam logic [2:0] REG_SEG_SIZE   = 3'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] frame_number;
		logic [2:0]  entry_slot;
		logic [3:0]  entry_repeat_exp;
		logic [10:0] entry_position;
		logic [2:0]  block_kind;
		logic [11:0] block_bytes;
	} in_item_t;

	typedef struct packed {
		logic [10:0] frame_prime;
		logic [2:0]  segment_kind;
		logic [2:0]  sent_block;
		logic [11:0] seg_offset;
		logic [11:0] segment_total;
		logic [11:0] segment_number;
		logic [11:0] block_length_out;
	} out_item_t;

	typedef struct packed {
		logic [2:0] index;
		logic [11:0] data;
	} cfg_req_t;

	// One classified tick handed from front to back.
	typedef struct packed {
		logic [11:0] frame;
		logic [2:0]  next_block;
		logic [11:0] next_length;
	} tick_req_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_SCAN,
		FR_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_OUT
	} back_state_t;

	// Position of a frame within a period of 2 << rep frames, in frame pairs.
	function automatic logic [10:0] frame_pos(input logic [11:0] frame,
		input logic [3:0] rep);
		logic [11:0] mask;
		logic [11:0] m;
		begin
			mask = (12'd2 << rep) - 12'd1;
			if (rep >= 4'd11) begin
				mask = 12'hFFF;
			end
			m = frame & mask;
			frame_pos = m[11:1];
		end
	endfunction

endpackage

// File: rtl/core/bbss_front.sv
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts requests, keeps the tables and picks the block of each tick.
// ----------------------------------------------------------------------------
module bbss_front #(
	parameter int SCHED_ENTRIES   = bbss_pkg::SCHED_ENTRIES_DEF,
	parameter int MAX_BLOCK_BYTES = bbss_pkg::MAX_BLOCK_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bbss_pkg::in_item_t  in_item,
	input  logic [3:0]          master_rep,
	input  logic [10:0]         master_pos,
	input  logic [10:0]         sib1_pos,
	output logic                push,
	output bbss_pkg::tick_req_t push_req,
	input  logic                q_full
);
	localparam int IW = (SCHED_ENTRIES > 1) ? $clog2(SCHED_ENTRIES) : 1;
	localparam int CW = $clog2(SCHED_ENTRIES + 1);
	localparam int LEN_CAP = (MAX_BLOCK_BYTES > 4095) ? 4095 : MAX_BLOCK_BYTES;

	logic [3:0]  rep_q [SCHED_ENTRIES];
	logic [10:0] pos_q [SCHED_ENTRIES];
	logic [2:0]  blk_q [SCHED_ENTRIES];
	logic [11:0] len_q [8];
	logic        sib1_pend_q;

	bbss_pkg::front_state_t state_q, state_d;
	logic [11:0] frame_q;
	logic [2:0]  pick_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] idx;
	logic [IW-1:0] wr_slot;
	logic        accept;
	logic        hit;
	logic [11:0] raw_len;

	assign in_ready = (state_q == bbss_pkg::FR_IDLE);
	assign accept   = in_valid && in_ready;
	assign idx      = idx_q[IW-1:0];
	assign wr_slot  = IW'(in_item.entry_slot);
	assign hit      = (rep_q[idx] != 4'd0) &&
		(bbss_pkg::frame_pos(frame_q, rep_q[idx]) == pos_q[idx]);

	// Length lookup with saturation.
	always_comb begin
		raw_len = len_q[pick_q];
		if (pick_q == bbss_pkg::BLK_UNKNOWN) begin
			raw_len = (bbss_pkg::UNKNOWN_LEN > LEN_CAP) ? 12'(LEN_CAP)
				: 12'(bbss_pkg::UNKNOWN_LEN);
		end else if (32'(raw_len) > 32'(LEN_CAP)) begin
			raw_len = 12'(LEN_CAP);
		end
		if (pick_q == bbss_pkg::BLK_NONE) begin
			raw_len = 12'd0;
		end
	end

	assign push             = (state_q == bbss_pkg::FR_PUSH) && !q_full;
	assign push_req.frame       = frame_q;
	assign push_req.next_block  = pick_q;
	assign push_req.next_length = raw_len;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bbss_pkg::FR_IDLE: begin
				if (accept && in_item.kind == bbss_pkg::KIND_TICK) begin
					state_d = bbss_pkg::FR_SCAN;
				end
			end
			bbss_pkg::FR_SCAN: begin
				if (pick_q != bbss_pkg::BLK_NONE || hit ||
					idx_q == CW'(SCHED_ENTRIES - 1)) begin
					state_d = bbss_pkg::FR_PUSH;
				end
			end
			bbss_pkg::FR_PUSH: begin
				if (!q_full) begin
					state_d = bbss_pkg::FR_IDLE;
				end
			end
			default: state_d = bbss_pkg::FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbss_pkg::FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Tables, one-shot flag and scan registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SCHED_ENTRIES; i++) begin
				rep_q[i] <= 4'd0;
				pos_q[i] <= 11'd0;
				blk_q[i] <= 3'd0;
			end
			for (int i = 0; i < 8; i++) begin
				len_q[i] <= 12'd0;
			end
			sib1_pend_q <= 1'b1;
			frame_q     <= 12'd0;
			pick_q      <= 3'd0;
			idx_q       <= '0;
		end else begin
			if (accept) begin
				case (in_item.kind)
					bbss_pkg::KIND_SCHED: begin
						if (32'(in_item.entry_slot) < SCHED_ENTRIES) begin
							rep_q[wr_slot] <= in_item.entry_repeat_exp;
							pos_q[wr_slot] <= in_item.entry_position;
							blk_q[wr_slot] <= in_item.block_kind;
						end
					end
					bbss_pkg::KIND_LENGTH: begin
						len_q[in_item.block_kind] <= in_item.block_bytes;
					end
					bbss_pkg::KIND_TICK: begin
						// Master first, then the one-shot block; table scan follows.
						frame_q <= in_item.frame_number;
						idx_q   <= '0;
						if (bbss_pkg::frame_pos(in_item.frame_number, master_rep)
							== master_pos) begin
							pick_q <= bbss_pkg::BLK_MASTER;
						end else if (bbss_pkg::frame_pos(in_item.frame_number, master_rep)
							== sib1_pos && sib1_pend_q) begin
							pick_q      <= bbss_pkg::BLK_SIB1;
							sib1_pend_q <= 1'b0;
						end else begin
							pick_q <= bbss_pkg::BLK_NONE;
						end
					end
					default: ;
				endcase
			end
			if (state_q == bbss_pkg::FR_SCAN && pick_q == bbss_pkg::BLK_NONE) begin
				if (hit) begin
					pick_q <= blk_q[idx];
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
		end
	end
endmodule

// File: rtl/core/bbss_queue.sv
// ----------------------------------------------------------------------------
// Tick queue
// Short FIFO between the front end and the segmenter.
// ----------------------------------------------------------------------------
module bbss_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bbss_pkg::tick_req_t push_req,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output bbss_pkg::tick_req_t pop_req
);
	localparam int D = bbss_pkg::QUEUE_DEPTH;
	localparam int AW = $clog2(D);

	bbss_pkg::tick_req_t mem_q [D];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign full      = (cnt_q == (AW+1)'(D));
	assign not_empty = (cnt_q != '0);
	assign pop_req   = mem_q[rd_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_req;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// File: rtl/core/bbss_back.sv
// ----------------------------------------------------------------------------
// Segmenter back end
// Holds the pending block and emits one segment descriptor per tick.
// ----------------------------------------------------------------------------
module bbss_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  bbss_pkg::tick_req_t q_req,
	output logic                q_pop,
	input  logic [11:0]         compl_lim,
	input  logic [11:0]         seg_size,
	output logic                out_valid,
	input  logic                out_ready,
	output bbss_pkg::out_item_t out_item
);
	bbss_pkg::back_state_t state_q, state_d;
	logic [2:0]  cur_blk_q;
	logic [11:0] cur_len_q, cur_off_q, seg_cnt_q;
	bbss_pkg::out_item_t res_q;
	logic [11:0] seg;
	// Restoring divider registers; the rounded-up numerator needs 13 bits.
	logic [11:0] quo_q, rem_q;
	logic [12:0] num_q;
	logic [3:0]  bit_q;
	logic [12:0] trial;
	logic [12:0] num_m1;

	assign seg       = (seg_size == 12'd0) ? 12'd1 : seg_size;
	assign out_valid = (state_q == bbss_pkg::BK_OUT);
	assign out_item  = res_q;
	assign q_pop     = (state_q == bbss_pkg::BK_IDLE) && q_valid;
	assign trial     = {rem_q, num_q[12]} - {1'b0, seg};
	assign num_m1    = {1'b0, q_req.next_length} + {1'b0, seg} - 13'd1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bbss_pkg::BK_IDLE: begin
				if (q_valid) begin
					if (cur_blk_q == bbss_pkg::BLK_NONE &&
						q_req.next_length > compl_lim) begin
						state_d = bbss_pkg::BK_DIV;
					end else begin
						state_d = bbss_pkg::BK_OUT;
					end
				end
			end
			bbss_pkg::BK_DIV: begin
				if (bit_q == 4'd12) begin
					state_d = bbss_pkg::BK_OUT;
				end
			end
			bbss_pkg::BK_OUT: begin
				if (out_ready) begin
					state_d = bbss_pkg::BK_IDLE;
				end
			end
			default: state_d = bbss_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbss_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Block state and result formation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_blk_q <= 3'd0;
			cur_len_q <= 12'd0;
			cur_off_q <= 12'd0;
			seg_cnt_q <= 12'd0;
			bit_q     <= 4'd0;
			quo_q     <= 12'd0;
			rem_q     <= 12'd0;
			num_q     <= 13'd0;
			res_q     <= '0;
		end else begin
			if (q_pop) begin
				res_q.frame_prime    <= q_req.frame[10:0];
				res_q.segment_total  <= 12'd0;
				if (cur_blk_q == bbss_pkg::BLK_NONE) begin
					// Take up the newly picked block.
					cur_len_q              <= q_req.next_length;
					res_q.block_length_out <= q_req.next_length;
					res_q.sent_block       <= q_req.next_block;
					res_q.seg_offset       <= 12'd0;
					res_q.segment_number   <= 12'd0;
					if (q_req.next_length <= compl_lim) begin
						if (q_req.next_length == 12'd0) begin
							res_q.segment_kind <= bbss_pkg::SEG_NONE;
							cur_blk_q          <= q_req.next_block;
						end else begin
							res_q.segment_kind <= bbss_pkg::SEG_COMPL;
							cur_blk_q          <= bbss_pkg::BLK_NONE;
						end
					end else begin
						res_q.segment_kind <= bbss_pkg::SEG_FIRST;
						cur_blk_q <= q_req.next_block;
						seg_cnt_q <= 12'd0;
						cur_off_q <= cur_off_q + seg;
						num_q     <= num_m1;
						rem_q     <= 12'd0;
						quo_q     <= 12'd0;
						bit_q     <= 4'd0;
					end
				end else begin
					// Continue the pending block.
					res_q.sent_block       <= cur_blk_q;
					res_q.block_length_out <= cur_len_q;
					res_q.segment_number   <= seg_cnt_q + 12'd1;
					res_q.seg_offset       <= cur_off_q;
					seg_cnt_q              <= seg_cnt_q + 12'd1;
					if (cur_off_q >= cur_len_q || (cur_len_q - cur_off_q) <= seg) begin
						res_q.segment_kind <= bbss_pkg::SEG_LAST;
						cur_blk_q          <= bbss_pkg::BLK_NONE;
						cur_off_q          <= 12'd0;
					end else begin
						res_q.segment_kind <= bbss_pkg::SEG_SUBS;
						cur_off_q          <= cur_off_q + seg;
					end
				end
			end
			// One quotient bit per cycle.
			if (state_q == bbss_pkg::BK_DIV) begin
				num_q <= {num_q[11:0], 1'b0};
				bit_q <= bit_q + 4'd1;
				if (!trial[12]) begin
					rem_q <= trial[11:0];
					quo_q <= {quo_q[10:0], 1'b1};
					if (bit_q == 4'd12) begin
						res_q.segment_total <= {quo_q[10:0], 1'b1};
					end
				end else begin
					rem_q <= {rem_q[10:0], num_q[12]};
					quo_q <= {quo_q[10:0], 1'b0};
					if (bit_q == 4'd12) begin
						res_q.segment_total <= {quo_q[10:0], 1'b0};
					end
				end
			end
		end
	end
endmodule

// File: rtl/core/broadcast_block_scheduler_segmenter.sv
// ----------------------------------------------------------------------------
// Broadcast block scheduler and segmenter
// Picks the block due each frame tick and emits one segment descriptor.
// ----------------------------------------------------------------------------
// A tick's result passes the front end table scan, the tick queue and, for a first
// segment, the bit-serial segment count divider.
// Table writes are accepted only while the front end is idle; ticks are bounded by the
// front end table scan and the divider.
// Reset clears the tables, state and registers to their defaults at once.
module broadcast_block_scheduler_segmenter #(
	parameter int SCHED_ENTRIES   = bbss_pkg::SCHED_ENTRIES_DEF,
	parameter int MAX_BLOCK_BYTES = bbss_pkg::MAX_BLOCK_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bbss_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output bbss_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  bbss_pkg::cfg_req_t  cfg
);
	logic [3:0]  master_rep_q;
	logic [10:0] master_pos_q, sib1_pos_q;
	logic [11:0] compl_lim_q, seg_size_q;
	logic push, q_full, q_pop, q_valid;
	bbss_pkg::tick_req_t push_req, pop_req;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_rep_q <= 4'd3;
			master_pos_q <= 11'd0;
			sib1_pos_q   <= 11'd1;
			compl_lim_q  <= 12'd28;
			seg_size_q   <= 12'd28;
		end else if (cfg_valid) begin
			case (cfg.index)
				bbss_pkg::REG_MASTER_REP: master_rep_q <= cfg.data[3:0];
				bbss_pkg::REG_MASTER_POS: master_pos_q <= cfg.data[10:0];
				bbss_pkg::REG_SIB1_POS:   sib1_pos_q   <= cfg.data[10:0];
				bbss_pkg::REG_COMPL_LIM:  compl_lim_q  <= cfg.data;
				bbss_pkg::REG_SEG_SIZE:   seg_size_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	bbss_front #(
		.SCHED_ENTRIES(SCHED_ENTRIES),
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.master_rep(master_rep_q), .master_pos(master_pos_q), .sib1_pos(sib1_pos_q),
		.push(push), .push_req(push_req), .q_full(q_full)
	);

	bbss_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_req(push_req), .full(q_full),
		.pop(q_pop), .not_empty(q_valid), .pop_req(pop_req)
	);

	bbss_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_req(pop_req), .q_pop(q_pop),
		.compl_lim(compl_lim_q), .seg_size(seg_size_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule

// File: rtl/core/bbss_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Checks the result channel of the scheduler and segmenter over time.
// ----------------------------------------------------------------------------
module bbss_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input bbss_pkg::out_item_t out_item
);
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Only defined segment kinds appear.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.segment_kind <= bbss_pkg::SEG_LAST)
		else $error("bad segment kind");

	// A first segment carries a count and starts at offset zero.
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.segment_kind == bbss_pkg::SEG_FIRST |->
		out_item.seg_offset == 12'd0 && out_item.segment_total != 12'd0)
		else $error("bad first segment");

	// A continuation segment carries no segment count.
	a_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.segment_kind == bbss_pkg::SEG_SUBS ||
		out_item.segment_kind == bbss_pkg::SEG_LAST) |->
		out_item.segment_total == 12'd0)
		else $error("continuation carries a count");
endmodule

bind broadcast_block_scheduler_segmenter bbss_checker u_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid),
	.out_ready(out_ready), .out_item(out_item)
);
